FILE: rtl/serial_multiformat_add_sub_unit_defines.svh
// Assertion macros for the checker of the serial add/sub unit.
// Depends on nothing; include by bare file name.
`ifndef SERIAL_MULTIFORMAT_ADD_SUB_UNIT_DEFINES_SVH
`define SERIAL_MULTIFORMAT_ADD_SUB_UNIT_DEFINES_SVH

// Concurrent check, switched off while reset is held.
`define SMAS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define SMAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/smas_pkg.sv
// Shared types and constants of the serial multi-format add/sub unit.
// Depends on nothing; imported by the datapath, the top level and the testbench files.
`timescale 1ns / 1ps
`default_nettype none

package smas_pkg;

    typedef enum logic [2:0] {
        MODE_BIN_ADD   = 3'd0,
        MODE_BIN_SUB   = 3'd1,
        MODE_ASCII_ADD = 3'd2,
        MODE_ASCII_SUB = 3'd3,
        MODE_BCD_ADD   = 3'd4,
        MODE_BCD_SUB   = 3'd5
    } mode_t;

    localparam int unsigned BYTE_W = 8;

    // ASCII digit adjustments
    localparam logic [7:0] ASCII_HI_ADJ  = 8'h26;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_OVF_ADJ = 8'h36;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_SUB_ADJ = 8'hC6;
    localparam logic [3:0] ASCII_NIB_6   = 4'h6;
    localparam logic [3:0] ASCII_NIB_7   = 4'h7;

    // Packed BCD digit limits, one nibble wide
    localparam logic [4:0] BCD_MAX_DIGIT = 5'd9;
    localparam logic [5:0] BCD_RADIX     = 6'd10;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic              carry;
        logic              bad_digit;
    } alu_out_t;

endpackage

`default_nettype wire

FILE: rtl/serial_multiformat_add_sub_unit.sv
// A request accepted into the input register moves on into the result register, which
// drives m_tvalid; it waits in the input register while the result register is full and
// m_tready is low. Throughput: one request per cycle while m_tready stays high; the only
// link between bytes is the one-bit running carry/borrow, updated in the same cycle the
// byte's result is registered.
// Reset (aresetn low, synchronous): empties both stages and clears the running carry.
`timescale 1ns / 1ps
`default_nettype none

module serial_multiformat_add_sub_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // byte_a [7:0], byte_b [15:8]
    input  wire logic [3:0]  s_tuser,   // mode [2:0], first [3]
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // result_byte [7:0]
    output      logic [1:0]  m_tuser    // carry_flag [0], bad_digit [1]
);
    import smas_pkg::*;

    // Input stage: holds one request until the result register can take it
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [2:0] in_mode_reg;
    logic       in_first_reg;
    logic [7:0] in_a_reg;
    logic [7:0] in_b_reg;

    // Running carry (add modes) or borrow (subtract modes) between bytes
    logic       carry_reg;
    logic       carry_in;

    // Result stage
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_carry_reg;
    logic       out_bad_reg;

    logic       advance;
    logic       s_accept;
    alu_out_t   alu_out;

    // Move the held request forward whenever the result slot is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // A first byte starts from a cleared carry, whatever the last run left
    assign carry_in = in_first_reg ? 1'b0 : carry_reg;

    smas_alu u_alu (
        .mode     (in_mode_reg),
        .carry_in (carry_in),
        .byte_a   (in_a_reg),
        .byte_b   (in_b_reg),
        .alu_out  (alu_out)
    );

    always_comb begin
        in_valid_next  = s_accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            carry_reg     <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                carry_reg <= alu_out.carry;
            end
        end
    end

    // Payload registers: load on accept / advance, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg  <= s_tuser[2:0];
            in_first_reg <= s_tuser[3];
            in_a_reg     <= s_tdata[7:0];
            in_b_reg     <= s_tdata[15:8];
        end
        if (advance) begin
            out_byte_reg  <= alu_out.result_byte;
            out_carry_reg <= alu_out.carry;
            out_bad_reg   <= alu_out.bad_digit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_bad_reg, out_carry_reg};

endmodule

`default_nettype wire

FILE: rtl/smas_alu.sv
// Combinational byte datapath: binary, ASCII-decimal and packed-BCD add/subtract.
// Depends on smas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smas_alu (
    input  wire logic [2:0]             mode,
    input  wire logic                   carry_in,
    input  wire logic [7:0]             byte_a,
    input  wire logic [7:0]             byte_b,
    output smas_pkg::alu_out_t          alu_out
);
    import smas_pkg::*;

    logic [8:0] bin_sum;
    logic [8:0] bin_dif;
    logic [7:0] asc_dif;
    logic [4:0] bcd_lo_sum;
    logic       bcd_lo_cy;
    logic [4:0] bcd_lo_adj;
    logic [4:0] bcd_hi_sum;
    logic       bcd_hi_cy;
    logic [4:0] bcd_hi_adj;
    logic [5:0] sub_lo_raw;
    logic [5:0] sub_lo_adj;
    logic [5:0] sub_hi_raw;
    logic [5:0] sub_hi_adj;

    always_comb begin
        bin_sum = {1'b0, byte_a} + {1'b0, byte_b} + {8'd0, carry_in};
        bin_dif = {1'b0, byte_b} + {1'b0, ~byte_a} + {8'd0, ~carry_in};
        asc_dif = byte_b - byte_a - {7'd0, carry_in};

        // BCD add: low digit, then high digit with the inner carry
        bcd_lo_sum = {1'b0, byte_a[3:0]} + {1'b0, byte_b[3:0]} + {4'd0, carry_in};
        bcd_lo_cy  = bcd_lo_sum > BCD_MAX_DIGIT;
        bcd_lo_adj = bcd_lo_cy ? bcd_lo_sum - BCD_RADIX[4:0] : bcd_lo_sum;
        bcd_hi_sum = {1'b0, byte_a[7:4]} + {1'b0, byte_b[7:4]} + {4'd0, bcd_lo_cy};
        bcd_hi_cy  = bcd_hi_sum > BCD_MAX_DIGIT;
        bcd_hi_adj = bcd_hi_cy ? bcd_hi_sum - BCD_RADIX[4:0] : bcd_hi_sum;

        // BCD subtract in six-bit two's complement; bit 5 is the borrow
        sub_lo_raw = {2'd0, byte_b[3:0]} - {2'd0, byte_a[3:0]} - {5'd0, carry_in};
        sub_lo_adj = sub_lo_raw[5] ? sub_lo_raw + BCD_RADIX : sub_lo_raw;
        sub_hi_raw = {2'd0, byte_b[7:4]} - {2'd0, byte_a[7:4]} - {5'd0, sub_lo_raw[5]};
        sub_hi_adj = sub_hi_raw[5] ? sub_hi_raw + BCD_RADIX : sub_hi_raw;

        alu_out.result_byte = '0;
        alu_out.carry       = carry_in;
        alu_out.bad_digit   = 1'b0;

        unique case (mode)
            MODE_BIN_ADD: begin
                alu_out.result_byte = bin_sum[7:0];
                alu_out.carry       = bin_sum[8];
            end
            MODE_BIN_SUB: begin
                alu_out.result_byte = bin_dif[7:0];
                alu_out.carry       = ~bin_dif[8];
            end
            MODE_ASCII_ADD: begin
                if (bin_sum[7:4] == ASCII_NIB_6) begin
                    if (bin_sum[3:0] >= 4'hA) begin
                        alu_out.result_byte = {4'd0, bin_sum[3:0]} + ASCII_HI_ADJ;
                        alu_out.carry       = 1'b1;
                    end else begin
                        alu_out.result_byte = {4'd0, bin_sum[3:0]} + ASCII_ZERO;
                        alu_out.carry       = 1'b0;
                    end
                end else if (bin_sum[7:4] == ASCII_NIB_7) begin
                    alu_out.result_byte = {4'd0, bin_sum[3:0]} + ASCII_OVF_ADJ;
                    alu_out.carry       = 1'b1;
                end else begin
                    // not a digit: output zero, hold the carry
                    alu_out.bad_digit = 1'b1;
                end
            end
            MODE_ASCII_SUB: begin
                if (asc_dif > ASCII_NINE) begin
                    alu_out.result_byte = asc_dif - ASCII_SUB_ADJ;
                    alu_out.carry       = 1'b1;
                end else begin
                    alu_out.result_byte = {4'd0, asc_dif[3:0]} + ASCII_ZERO;
                    alu_out.carry       = 1'b0;
                end
            end
            MODE_BCD_ADD: begin
                alu_out.result_byte = {bcd_hi_adj[3:0], 4'd0} + {3'd0, bcd_lo_adj};
                alu_out.carry       = bcd_hi_cy;
            end
            MODE_BCD_SUB: begin
                alu_out.result_byte = {sub_hi_adj[3:0], 4'd0}
                                    + {{2{sub_lo_adj[5]}}, sub_lo_adj};
                alu_out.carry       = sub_hi_raw[5];
            end
            default: begin
                alu_out.result_byte = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/smas_checker.sv
// Port-level checks for the serial multi-format add/sub unit, bound to the top level.
// Depends on serial_multiformat_add_sub_unit_defines.svh and the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_multiformat_add_sub_unit_defines.svh"

module smas_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [1:0]  m_tuser
);
    // a bad ASCII digit always comes out as a zero byte
    property p_bad_zero;
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 8'd0);
    endproperty

    // with the result slot empty, the input side must be open
    property p_ready_empty;
        (!m_tvalid) |-> s_tready;
    endproperty

    // a stalled result holds its payload
    property p_out_hold;
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser));
    endproperty

    // reset empties the result stage
    property p_reset_empty;
        (!aresetn) |=> (!m_tvalid);
    endproperty

    `SMAS_ASSERT(a_bad_digit_zero, aclk, aresetn, p_bad_zero, "bad digit, nonzero result")
    `SMAS_ASSERT(a_ready_when_empty, aclk, aresetn, p_ready_empty, "input stalled, slot empty")
    `SMAS_ASSERT(a_out_hold, aclk, aresetn, p_out_hold, "stalled result changed")
    `SMAS_ASSERT_ALWAYS(a_reset_empty, aclk, p_reset_empty, "result valid after reset")

endmodule

bind serial_multiformat_add_sub_unit smas_checker u_smas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/addsub_result_checker.sv
// Watches both streams of the serial add/sub unit, predicts each result byte and compares.
// Depends on smas_pkg for the mode codes, the ASCII constants and the result struct.
`timescale 1ns / 1ps

module addsub_result_checker
    import smas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_a [7:0], byte_b [15:8]
    input  logic [3:0]  s_tuser,   // mode [2:0], first [3]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // result_byte [7:0]
    input  logic [1:0]  m_tuser,   // carry_flag [0], bad_digit [1]
    output int          mismatch_count,
    output int          results_seen,
    output int          pending_results
);

    alu_out_t expected_sums[$];
    logic     carry_state = 1'b0;
    int       errors      = 0;
    int       seen        = 0;

    // Compute one byte of the selected format; the returned carry is the new running bit.
    function automatic alu_out_t predict_byte(input logic [2:0] mode, input logic [7:0] a,
                                              input logic [7:0] b, input logic carry_in);
        alu_out_t  r;
        logic [8:0] sum9;
        logic [7:0] s8;
        int         lo;
        int         hi;
        int         c;
        r             = '0;
        r.carry       = carry_in;
        case (mode)
            MODE_BIN_ADD: begin
                sum9          = {1'b0, a} + {1'b0, b} + 9'(carry_in);
                r.result_byte = sum9[7:0];
                r.carry       = sum9[8];
            end
            MODE_BIN_SUB: begin
                sum9          = {1'b0, b} + {1'b0, ~a} + 9'(!carry_in);
                r.result_byte = sum9[7:0];
                r.carry       = !sum9[8];
            end
            MODE_ASCII_ADD: begin
                s8 = a + b + 8'(carry_in);
                if (s8[7:4] == ASCII_NIB_6) begin
                    if (s8[3:0] >= 4'hA) begin
                        r.result_byte = {4'h0, s8[3:0]} + ASCII_HI_ADJ;
                        r.carry       = 1'b1;
                    end else begin
                        r.result_byte = {4'h0, s8[3:0]} + ASCII_ZERO;
                        r.carry       = 1'b0;
                    end
                end else if (s8[7:4] == ASCII_NIB_7) begin
                    r.result_byte = {4'h0, s8[3:0]} + ASCII_OVF_ADJ;
                    r.carry       = 1'b1;
                end else begin
                    // not a digit: zero out, flag it, keep the carry
                    r.bad_digit = 1'b1;
                end
            end
            MODE_ASCII_SUB: begin
                s8 = b - a - 8'(carry_in);
                if (s8 > ASCII_NINE) begin
                    r.result_byte = s8 - ASCII_SUB_ADJ;
                    r.carry       = 1'b1;
                end else begin
                    r.result_byte = {4'h0, s8[3:0]} + ASCII_ZERO;
                    r.carry       = 1'b0;
                end
            end
            MODE_BCD_ADD: begin
                lo = int'(a[3:0]) + int'(b[3:0]) + int'(carry_in);
                c  = 0;
                if (lo > 9) begin
                    lo = lo - 10;
                    c  = 1;
                end
                hi = int'(a[7:4]) * 16 + int'(b[7:4]) * 16 + c * 16;
                r.carry = (hi > 'h90);
                if (r.carry) hi = hi - 'hA0;
                r.result_byte = 8'(hi + lo);
            end
            MODE_BCD_SUB: begin
                lo = int'(b[3:0]) - int'(a[3:0]) - int'(carry_in);
                c  = 0;
                if (lo < 0) begin
                    lo = lo + 10;
                    c  = 1;
                end
                hi = int'(b[7:4]) * 16 - int'(a[7:4]) * 16 - c * 16;
                r.carry = (hi < 0);
                if (r.carry) hi = hi + 'hA0;
                r.result_byte = 8'(hi + lo);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        alu_out_t want;
        logic     carry_in;
        if (!aresetn) begin
            carry_state = 1'b0;
            expected_sums.delete();
        end else begin
            // retire the oldest prediction before adding this edge's request
            if (m_tvalid && m_tready) begin
                seen++;
                if (expected_sums.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: unexpected result byte %h carry %b bad %b",
                                 $realtime, m_tdata, m_tuser[0], m_tuser[1]);
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== want.result_byte || m_tuser[0] !== want.carry ||
                        m_tuser[1] !== want.bad_digit) begin
                        errors++;
                        if (errors <= 10)
                            $display("%t: expected byte %h carry %b bad %b, got %h %b %b",
                                     $realtime, want.result_byte, want.carry,
                                     want.bad_digit, m_tdata, m_tuser[0], m_tuser[1]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                carry_in    = s_tuser[3] ? 1'b0 : carry_state;
                want        = predict_byte(s_tuser[2:0], s_tdata[7:0], s_tdata[15:8], carry_in);
                carry_state = want.carry;
                expected_sums.push_back(want);
            end
        end
        mismatch_count  <= errors;
        results_seen    <= seen;
        pending_results <= expected_sums.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the serial add/sub unit bench: clock, reset, request stimulus and the verdict.
// Depends on smas_pkg, the unit itself and addsub_result_checker.
`timescale 1ns / 1ps

module testbench;
    import smas_pkg::*;

    // codes the package enum leaves out; the unit must pass the carry through
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam int         RANDOM_PER_PHASE = 517;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // byte_a [7:0], byte_b [15:8]
    logic [3:0]  s_tuser  = '0;   // mode [2:0], first [3]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // result_byte [7:0]
    logic [1:0]  m_tuser;         // carry_flag [0], bad_digit [1]

    int mismatch_count;
    int results_seen;
    int pending_results;
    int requests_sent = 0;
    int tx_idle_pct   = 21;
    int rx_idle_pct   = 79;

    // 4 ns period: two ns high, two ns low
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    serial_multiformat_add_sub_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    addsub_result_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_seen    (results_seen),
        .pending_results (pending_results)
    );

    // Stall the result side at random; at zero percent the receiver never stalls.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Offer one request and hold it until the unit takes it. Idle cycles go in front,
    // so gaps land before every kind of byte.
    task automatic send_request(input logic [2:0] mode, input logic first,
                                input logic [7:0] byte_a, input logic [7:0] byte_b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {byte_b, byte_a};
        s_tuser  <= {first, mode};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Pick an operand byte that suits the format: mostly legal digits, some junk.
    function automatic logic [7:0] operand_byte(input logic [2:0] mode);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0) begin
            case (mode)
                MODE_ASCII_ADD, MODE_ASCII_SUB: v = ASCII_ZERO + 8'($urandom_range(0, 9));
                MODE_BCD_ADD, MODE_BCD_SUB:
                    v = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                default: if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
        end
        return v;
    endfunction

    // Send a whole multi-byte operation: first byte flagged, the rest chained on the carry.
    task automatic send_operation();
        logic [2:0] mode;
        int         len;
        mode = 3'($urandom_range(0, 5));
        len  = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_request(mode, i == 0, operand_byte(mode), operand_byte(mode));
    endtask

    initial begin
        // hold reset low at the start, then release it for good
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // binary: full carry out and in, a clean subtract, borrow with B at zero, borrow chained
        send_request(MODE_BIN_ADD, 1'b1, 8'hFF, 8'hFF);
        send_request(MODE_BIN_ADD, 1'b0, 8'h00, 8'h00);
        send_request(MODE_BIN_SUB, 1'b1, 8'h00, 8'h00);
        send_request(MODE_BIN_SUB, 1'b1, 8'h01, 8'h00);
        send_request(MODE_BIN_SUB, 1'b0, 8'hFF, 8'hFF);
        // ASCII add: high nibble seven, low digit over nine, plain digit
        send_request(MODE_ASCII_ADD, 1'b1, 8'h39, 8'h39);
        send_request(MODE_ASCII_ADD, 1'b0, 8'h35, 8'h34);
        send_request(MODE_ASCII_ADD, 1'b0, 8'h30, 8'h30);
        // ASCII add bad digit, once with carry clear and once with carry kept high
        send_request(MODE_ASCII_ADD, 1'b1, 8'h00, 8'h00);
        send_request(MODE_ASCII_ADD, 1'b1, 8'h39, 8'h39);
        send_request(MODE_ASCII_ADD, 1'b0, 8'hFF, 8'hFF);
        // ASCII subtract: borrow out, borrow chained, clean digit
        send_request(MODE_ASCII_SUB, 1'b1, 8'h35, 8'h33);
        send_request(MODE_ASCII_SUB, 1'b0, 8'h30, 8'h30);
        send_request(MODE_ASCII_SUB, 1'b0, 8'h30, 8'h39);
        // packed BCD add and subtract: 99 + 99, carry and borrow in, non-decimal nibbles
        send_request(MODE_BCD_ADD, 1'b1, 8'h99, 8'h99);
        send_request(MODE_BCD_ADD, 1'b0, 8'h00, 8'h00);
        send_request(MODE_BCD_ADD, 1'b1, 8'hFF, 8'hFF);
        send_request(MODE_BCD_SUB, 1'b1, 8'h01, 8'h00);
        send_request(MODE_BCD_SUB, 1'b0, 8'h00, 8'h00);
        send_request(MODE_BCD_SUB, 1'b1, 8'hFF, 8'h0F);
        // spare modes pass the running bit through, with and without clearing
        send_request(MODE_SPARE_6, 1'b0, 8'hA5, 8'h5A);
        send_request(MODE_SPARE_7, 1'b1, 8'hFF, 8'hFF);
        // one running bit shared across formats
        send_request(MODE_BIN_ADD, 1'b1, 8'hFF, 8'h01);
        send_request(MODE_BCD_ADD, 1'b0, 8'h00, 8'h00);
        send_request(MODE_ASCII_SUB, 1'b0, 8'h31, 8'h30);

        // three idle mixes: sender light / receiver heavy, swapped, then none
        for (int phase = 0; phase < 3; phase++) begin : phases
            int phase_start;
            tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 79 : 0;
            rx_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 21 : 0;
            phase_start = requests_sent;
            while (requests_sent - phase_start < RANDOM_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85)
                    send_operation();
                else
                    // noise: any mode code, random first flag and bytes
                    send_request(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;

        // drain: let the checker see the last request, then wait out the pipeline
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d requests across binary, ASCII and BCD add/sub plus spare codes,",
                 requests_sent);
        $display("checked %0d results under three sender/receiver stall mixes.", results_seen);
        if (mismatch_count == 0) begin
            $display("serial_multiformat_add_sub_unit: match");
        end else begin
            $display("serial_multiformat_add_sub_unit: mismatch");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("serial_multiformat_add_sub_unit: mismatch");
        $finish;
    end

endmodule
